@@ design/char_lcd_nibble_write_sequencer_macros.svh @@
// assertion helpers used by the sequencer back-end module
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_MACROS_SVH

// same-cycle implication
`define CLCD_ASSERT_IMP(lbl, ck, rn, a, c, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define CLCD_ASSERT_NXT(lbl, ck, rn, a, c, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) else $error(msg);

`endif

@@ design/clcd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package clcd_pkg;

    typedef enum logic [1:0] {
        OPC_INIT   = 2'd0,
        OPC_CMD    = 2'd1,
        OPC_DATA   = 2'd2,
        OPC_CURSOR = 2'd3
    } opcode_t;

    typedef enum logic {
        KIND_INIT = 1'b0,
        KIND_BYTE = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        REG_POWERUP  = 3'd0,
        REG_SETUP    = 3'd1,
        REG_EN_HIGH  = 3'd2,
        REG_EN_LOW   = 3'd3,
        REG_CLEAR    = 3'd4
    } reg_index_t;

    localparam int unsigned PADDR_W = 5;
    localparam int unsigned QDEPTH  = 2;
    localparam int unsigned QAW     = 1;
    localparam int unsigned QCW     = 2;
    localparam int unsigned PHASE_W = 4;

    localparam logic [PHASE_W-1:0] BYTE_LAST_PHASE = 4'd6;
    localparam logic [PHASE_W-1:0] INIT_LAST_PHASE = 4'd10;

    localparam logic [15:0] POWERUP_RST  = 16'd40000;
    localparam logic [7:0]  SETUP_RST    = 8'd1;
    localparam logic [7:0]  EN_HIGH_RST  = 8'd20;
    localparam logic [9:0]  EN_LOW_RST   = 10'd100;
    localparam logic [15:0] CLEAR_RST    = 16'd2000;

    localparam logic [7:0]  WIDE_LIMIT   = 8'h80;
    localparam logic [7:0]  WIDE_ADD     = 8'hB0;
    localparam logic [7:0]  DDRAM_CMD    = 8'h80;
    localparam logic [7:0]  ROW1_OFS     = 8'h00;
    localparam logic [7:0]  ROW2_OFS     = 8'h40;
    localparam logic [7:0]  ROW3_OFS     = 8'h14;
    localparam logic [7:0]  ROW4_OFS     = 8'h54;
    localparam logic [7:0]  CLEAR_CMD    = 8'h01;
    localparam logic [3:0]  INIT_NIB_8B  = 4'h3;
    localparam logic [3:0]  INIT_NIB_4B  = 4'h2;
    localparam logic [16:0] HOLD_MAX     = 17'd65535;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] value;
        logic [7:0]  row;
        logic [6:0]  column;
    } cmd_t;

    typedef struct packed {
        logic        reg_select;
        logic        enable;
        logic [3:0]  nibble;
        logic [15:0] hold_us;
        logic        last;
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic        sel;
        logic [7:0]  data;
        logic        is_cmd;
        logic        is_clear;
    } qent_t;

    typedef struct packed {
        logic [15:0] powerup_wait_us;
        logic [7:0]  setup_us;
        logic [7:0]  enable_high_us;
        logic [9:0]  enable_low_us;
        logic [15:0] clear_extra_us;
    } cfg_t;

endpackage
`default_nettype wire

@@ design/char_lcd_nibble_write_sequencer.sv @@
// channel  | direction | handshake               | beat payload
// cmd      | in        | cmd_valid / cmd_stall   | cmd_t: opcode, value, row, column
// phase    | out       | phase_valid / phase_stall | phase_t: reg_select, enable, nibble,
//          |           |                         |          hold_us, last
// apb      | in        | psel / penable / pready | paddr, pwdata, prdata
//
// one phase beat per cycle while phase_stall is low: byte op 7 beats, init 11, bad cursor row none
// the back-end phase counter sets the rate; a 2-entry queue lets a new op enter meanwhile
// reset clears the queue, the phase counter, the output valid flag and pin state
// phase_stall holds the output register and the phase counter; the front keeps taking ops until the queue fills
`timescale 1ns / 1ps
`default_nettype none
module char_lcd_nibble_write_sequencer
    import clcd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire cmd_t               cmd,
    output logic                    phase_valid,
    input  wire logic               phase_stall,
    output phase_t                  phase,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    cfg_t  cfg;
    logic  q_full;
    logic  q_push;
    logic  q_pop;
    logic  q_not_empty;
    qent_t q_in;
    qent_t q_head;

    clcd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    clcd_front u_front (
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    clcd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    clcd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .phase_valid (phase_valid),
        .phase_stall (phase_stall),
        .phase       (phase)
    );

endmodule
`default_nettype wire

@@ design/clcd_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
module clcd_regs
    import clcd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t idx;
    logic       wr_en;

    assign idx    = reg_index_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_POWERUP: cfg_next.powerup_wait_us = pwdata[15:0];
                REG_SETUP:   cfg_next.setup_us        = pwdata[7:0];
                REG_EN_HIGH: cfg_next.enable_high_us  = pwdata[7:0];
                REG_EN_LOW:  cfg_next.enable_low_us   = pwdata[9:0];
                REG_CLEAR:   cfg_next.clear_extra_us  = pwdata[15:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_POWERUP: prdata = {16'd0, cfg_reg.powerup_wait_us};
            REG_SETUP:   prdata = {24'd0, cfg_reg.setup_us};
            REG_EN_HIGH: prdata = {24'd0, cfg_reg.enable_high_us};
            REG_EN_LOW:  prdata = {22'd0, cfg_reg.enable_low_us};
            REG_CLEAR:   prdata = {16'd0, cfg_reg.clear_extra_us};
            default:     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.powerup_wait_us <= POWERUP_RST;
            cfg_reg.setup_us        <= SETUP_RST;
            cfg_reg.enable_high_us  <= EN_HIGH_RST;
            cfg_reg.enable_low_us   <= EN_LOW_RST;
            cfg_reg.clear_extra_us  <= CLEAR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

@@ design/clcd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module clcd_front
    import clcd_pkg::*;
(
    input  wire logic cmd_valid,
    output logic      cmd_stall,
    input  wire cmd_t cmd,
    input  wire logic q_full,
    output logic      q_push,
    output qent_t     q_data
);

    opcode_t    opc;
    logic [7:0] ofs;
    logic       row_ok;
    logic [7:0] ch;

    assign opc       = opcode_t'(cmd.opcode);
    assign cmd_stall = q_full;

    always_comb
    begin
        row_ok = 1'b1;
        case (cmd.row)
            8'd1:    ofs = ROW1_OFS;
            8'd2:    ofs = ROW2_OFS;
            8'd3:    ofs = ROW3_OFS;
            8'd4:    ofs = ROW4_OFS;
            default:
            begin
                ofs    = ROW1_OFS;
                row_ok = 1'b0;
            end
        endcase
    end

    // wide codes are remapped into the display font page
    assign ch = (cmd.value > {8'd0, WIDE_LIMIT}) ? (cmd.value[7:0] + WIDE_ADD)
                                                 : cmd.value[7:0];

    always_comb
    begin
        q_data.kind     = KIND_BYTE;
        q_data.sel      = 1'b0;
        q_data.data     = cmd.value[7:0];
        q_data.is_cmd   = 1'b1;
        q_data.is_clear = 1'b0;
        q_push          = cmd_valid && !q_full;
        case (opc)
            OPC_INIT:
            begin
                q_data.kind = KIND_INIT;
            end
            OPC_CMD:
            begin
                q_data.is_clear = (cmd.value[7:0] == CLEAR_CMD);
            end
            OPC_DATA:
            begin
                q_data.sel    = 1'b1;
                q_data.data   = ch;
                q_data.is_cmd = 1'b0;
            end
            OPC_CURSOR:
            begin
                q_data.data = DDRAM_CMD | {1'b0, cmd.column} | ofs;
                q_push      = cmd_valid && !q_full && row_ok;
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ design/clcd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module clcd_queue
    import clcd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire qent_t push_data,
    input  wire logic  pop,
    output logic       full,
    output logic       not_empty,
    output qent_t      head
);

    qent_t            mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QCW-1:0]   count_reg;
    logic [QCW-1:0]   count_next;
    logic             do_pop;

    assign full      = (count_reg == QCW'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

@@ design/clcd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "char_lcd_nibble_write_sequencer_macros.svh"
module clcd_back
    import clcd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  q_not_empty,
    input  wire qent_t q_head,
    output logic       q_pop,
    output logic       phase_valid,
    input  wire logic  phase_stall,
    output phase_t     phase
);

    logic [PHASE_W-1:0] idx_reg;
    logic [PHASE_W-1:0] idx_next;
    logic               cur_sel_reg;
    logic               cur_sel_next;
    logic [3:0]         cur_nib_reg;
    logic [3:0]         cur_nib_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    phase_t             out_reg;
    phase_t             out_next;
    phase_t             ph;
    logic               emit;
    logic               is_last;
    logic [3:0]         hi;
    logic [3:0]         lo;
    logic [15:0]        mid_low;
    logic [16:0]        end_sum;
    logic [15:0]        end_low;
    logic [15:0]        eh;
    logic [15:0]        el;
    logic [15:0]        su;

    assign hi = q_head.data[7:4];
    assign lo = q_head.data[3:0];
    assign eh = {8'd0, cfg.enable_high_us};
    assign el = {6'd0, cfg.enable_low_us};
    assign su = {8'd0, cfg.setup_us};

    assign mid_low = el + (q_head.is_cmd ? su : 16'd0);
    assign end_sum = {1'b0, el}
                   + (q_head.is_clear ? {1'b0, cfg.clear_extra_us} : 17'd0);
    assign end_low = (end_sum > HOLD_MAX) ? HOLD_MAX[15:0] : end_sum[15:0];

    assign is_last = (q_head.kind == KIND_INIT) ? (idx_reg == INIT_LAST_PHASE)
                                                : (idx_reg == BYTE_LAST_PHASE);
    assign emit    = q_not_empty && (!out_valid_reg || !phase_stall);
    assign q_pop   = emit && is_last;

    always_comb
    begin
        ph.reg_select = q_head.sel;
        ph.enable     = 1'b0;
        ph.nibble     = cur_nib_reg;
        ph.hold_us    = su;
        ph.last       = is_last;
        if (q_head.kind == KIND_INIT)
        begin
            ph.reg_select = 1'b0;
            case (idx_reg)
                4'd0:
                begin
                    ph.reg_select = cur_sel_reg;
                    ph.hold_us    = cfg.powerup_wait_us;
                end
                4'd1:
                begin
                    ph.nibble  = INIT_NIB_8B;
                    ph.hold_us = 16'd0;
                end
                4'd2, 4'd4, 4'd6:
                begin
                    ph.enable  = 1'b1;
                    ph.nibble  = INIT_NIB_8B;
                    ph.hold_us = eh;
                end
                4'd3, 4'd5, 4'd7:
                begin
                    ph.nibble  = INIT_NIB_8B;
                    ph.hold_us = el;
                end
                4'd8:
                begin
                    ph.nibble  = INIT_NIB_4B;
                    ph.hold_us = 16'd0;
                end
                4'd9:
                begin
                    ph.enable  = 1'b1;
                    ph.nibble  = INIT_NIB_4B;
                    ph.hold_us = eh;
                end
                default:
                begin
                    ph.nibble  = INIT_NIB_4B;
                    ph.hold_us = el;
                end
            endcase
        end
        else
        begin
            case (idx_reg)
                4'd0:
                begin
                    ph.nibble = cur_nib_reg;
                end
                4'd1:
                begin
                    ph.nibble = hi;
                end
                4'd2:
                begin
                    ph.enable  = 1'b1;
                    ph.nibble  = hi;
                    ph.hold_us = eh;
                end
                4'd3:
                begin
                    ph.nibble  = hi;
                    ph.hold_us = mid_low;
                end
                4'd4:
                begin
                    ph.nibble = lo;
                end
                4'd5:
                begin
                    ph.enable  = 1'b1;
                    ph.nibble  = lo;
                    ph.hold_us = eh;
                end
                default:
                begin
                    ph.nibble  = lo;
                    ph.hold_us = end_low;
                end
            endcase
        end
    end

    always_comb
    begin
        idx_next       = idx_reg;
        cur_sel_next   = cur_sel_reg;
        cur_nib_next   = cur_nib_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && phase_stall;
        if (emit)
        begin
            out_next       = ph;
            out_valid_next = 1'b1;
            idx_next       = is_last ? '0 : idx_reg + 1'b1;
            if (is_last)
            begin
                cur_sel_next = ph.reg_select;
                cur_nib_next = ph.nibble;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            cur_sel_reg   <= 1'b0;
            cur_nib_reg   <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            cur_sel_reg   <= cur_sel_next;
            cur_nib_reg   <= cur_nib_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign phase_valid = out_valid_reg;
    assign phase       = out_reg;

    `CLCD_ASSERT_IMP(a_byte_idx_range, clk, rst_n, q_not_empty && q_head.kind == KIND_BYTE, idx_reg <= BYTE_LAST_PHASE, "byte phase index out of range")
    `CLCD_ASSERT_IMP(a_idle_idx_zero, clk, rst_n, !q_not_empty, idx_reg == '0, "phase index moved with empty queue")
    `CLCD_ASSERT_NXT(a_pop_marks_last, clk, rst_n, q_pop, phase_valid && phase.last, "queue popped without a last beat")

endmodule
`default_nettype wire

@@ tb/sv/tb_char_lcd_nibble_write_sequencer.sv @@
`timescale 1ns / 1ps
module tb_char_lcd_nibble_write_sequencer;
    import clcd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned RANDOM_OPS   = 72;
    localparam int unsigned TAIL_OPS     = 20;

    logic               clk;
    logic               rst_n;
    logic               cmd_valid;
    logic               cmd_stall;
    cmd_t               cmd;
    logic               phase_valid;
    logic               phase_stall;
    phase_t             phase;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // timing registers and pin levels as the display bus should see them
    logic [15:0] powerup_wait;
    logic [7:0]  setup_hold;
    logic [7:0]  en_high_hold;
    logic [9:0]  en_low_hold;
    logic [15:0] clear_extra;
    logic        pin_select;
    logic [3:0]  pin_nibble;

    phase_t      expected_phases[$];
    phase_t      want_phase;
    int unsigned err_cnt = 0;
    int unsigned ops_sent = 0;
    int unsigned ops_ignored = 0;
    int unsigned phases_seen = 0;
    int unsigned settings_used = 0;
    int unsigned cycle_cnt = 0;
    bit          send_gaps;
    bit          recv_stalls;

    char_lcd_nibble_write_sequencer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .phase_valid (phase_valid),
        .phase_stall (phase_stall),
        .phase       (phase),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("%0t timeout with %0d phases outstanding", $realtime,
                     expected_phases.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic push_phase(input logic sel, input logic en, input logic [3:0] nib,
                              input int unsigned hold, input logic last);
        phase_t p;
        p.reg_select = sel;
        p.enable     = en;
        p.nibble     = nib;
        p.hold_us    = (hold > 65535) ? 16'hFFFF : 16'(hold);
        p.last       = last;
        expected_phases.push_back(p);
    endtask

    task automatic expand_byte(input logic sel, input logic [7:0] b, input bit is_cmd);
        int unsigned mid_low;
        int unsigned end_low;
        mid_low = en_low_hold + (is_cmd ? setup_hold : 0);
        end_low = en_low_hold;
        if (is_cmd && b == CLEAR_CMD)
            end_low = end_low + clear_extra;
        push_phase(sel, 1'b0, pin_nibble, setup_hold, 1'b0);
        push_phase(sel, 1'b0, b[7:4], setup_hold, 1'b0);
        push_phase(sel, 1'b1, b[7:4], en_high_hold, 1'b0);
        push_phase(sel, 1'b0, b[7:4], mid_low, 1'b0);
        push_phase(sel, 1'b0, b[3:0], setup_hold, 1'b0);
        push_phase(sel, 1'b1, b[3:0], en_high_hold, 1'b0);
        push_phase(sel, 1'b0, b[3:0], end_low, 1'b1);
        pin_select = sel;
        pin_nibble = b[3:0];
    endtask

    task automatic expand_init();
        push_phase(pin_select, 1'b0, pin_nibble, powerup_wait, 1'b0);
        push_phase(1'b0, 1'b0, INIT_NIB_8B, 0, 1'b0);
        repeat (3)
        begin
            push_phase(1'b0, 1'b1, INIT_NIB_8B, en_high_hold, 1'b0);
            push_phase(1'b0, 1'b0, INIT_NIB_8B, en_low_hold, 1'b0);
        end
        push_phase(1'b0, 1'b0, INIT_NIB_4B, 0, 1'b0);
        push_phase(1'b0, 1'b1, INIT_NIB_4B, en_high_hold, 1'b0);
        push_phase(1'b0, 1'b0, INIT_NIB_4B, en_low_hold, 1'b1);
        pin_select = 1'b0;
        pin_nibble = INIT_NIB_4B;
    endtask

    task automatic expand_op(input cmd_t c);
        logic [7:0] ch;
        logic [7:0] ofs;
        case (opcode_t'(c.opcode))
            OPC_INIT:
                expand_init();
            OPC_CMD:
                expand_byte(1'b0, c.value[7:0], 1'b1);
            OPC_DATA:
            begin
                ch = (c.value > WIDE_LIMIT) ? c.value[7:0] + WIDE_ADD : c.value[7:0];
                expand_byte(1'b1, ch, 1'b0);
            end
            default:
            begin
                case (c.row)
                    8'd1: ofs = ROW1_OFS;
                    8'd2: ofs = ROW2_OFS;
                    8'd3: ofs = ROW3_OFS;
                    8'd4: ofs = ROW4_OFS;
                    default:
                    begin
                        ops_ignored++;
                        return;
                    end
                endcase
                expand_byte(1'b0, DDRAM_CMD | {1'b0, c.column} | ofs, 1'b1);
            end
        endcase
    endtask

    function automatic bit is_dropped(input cmd_t c);
        return c.opcode == OPC_CURSOR && (c.row < 8'd1 || c.row > 8'd4);
    endfunction

    function automatic cmd_t make_op(input opcode_t op, input logic [15:0] value,
                                     input logic [7:0] row, input logic [6:0] column);
        cmd_t c;
        c.opcode = op;
        c.value  = value;
        c.row    = row;
        c.column = column;
        return c;
    endfunction

    function automatic cmd_t random_op();
        cmd_t        c;
        int unsigned pick;
        c.value  = 16'($urandom());
        c.row    = 8'($urandom());
        c.column = 7'($urandom());
        pick = $urandom_range(0, 9);
        if (pick == 0)
            c.opcode = OPC_INIT;
        else if (pick <= 3)
            c.opcode = OPC_CMD;
        else if (pick <= 6)
            c.opcode = OPC_DATA;
        else
            c.opcode = OPC_CURSOR;
        if ($urandom_range(0, 2) != 0)
            c.value = {8'h00, c.value[7:0]};
        if (c.opcode == OPC_CMD && $urandom_range(0, 5) == 0)
            c.value[7:0] = CLEAR_CMD;
        if ($urandom_range(0, 4) != 0)
            c.row = 8'($urandom_range(1, 4));
        return c;
    endfunction

    task automatic send_op(input cmd_t c);
        int unsigned gap;
        gap = 0;
        if (send_gaps && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 4);
        @(negedge clk);
        if (gap != 0)
        begin
            cmd_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid = 1'b1;
        cmd       = c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        expand_op(c);
        ops_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        cmd_valid = 1'b0;
        while (expected_phases.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input reg_index_t idx, input logic [31:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'({idx, 2'b00});
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_POWERUP: powerup_wait = val[15:0];
            REG_SETUP:   setup_hold   = val[7:0];
            REG_EN_HIGH: en_high_hold = val[7:0];
            REG_EN_LOW:  en_low_hold  = val[9:0];
            default:     clear_extra  = val[15:0];
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_timing(input logic [31:0] pw, input logic [31:0] su,
                              input logic [31:0] eh, input logic [31:0] el,
                              input logic [31:0] ce);
        wait_idle();
        apb_write(REG_POWERUP, pw);
        apb_write(REG_SETUP, su);
        apb_write(REG_EN_HIGH, eh);
        apb_write(REG_EN_LOW, el);
        apb_write(REG_CLEAR, ce);
        settings_used++;
    endtask

    // reset timing values, every opcode, clear, wide characters, all cursor rows
    task automatic test_directed_ops();
        send_op(make_op(OPC_CURSOR, 16'h0000, 8'd1, 7'd0));
        send_op(make_op(OPC_INIT, 16'hFFFF, 8'hFF, 7'h7F));
        send_op(make_op(OPC_CMD, 16'h0001, 8'd0, 7'd0));
        send_op(make_op(OPC_CMD, 16'h00FF, 8'd0, 7'd0));
        send_op(make_op(OPC_CMD, 16'h0000, 8'd0, 7'd0));
        send_op(make_op(OPC_CMD, 16'hFF01, 8'd0, 7'd0));
        send_op(make_op(OPC_DATA, 16'h0080, 8'd0, 7'd0));
        send_op(make_op(OPC_DATA, 16'h0081, 8'd0, 7'd0));
        send_op(make_op(OPC_DATA, 16'hFFFF, 8'd0, 7'd0));
        send_op(make_op(OPC_DATA, 16'h007F, 8'd0, 7'd0));
        send_op(make_op(OPC_DATA, 16'h0000, 8'd0, 7'd0));
        send_op(make_op(OPC_CURSOR, 16'h0000, 8'd2, 7'h7F));
        send_op(make_op(OPC_CURSOR, 16'h0000, 8'd3, 7'd5));
        send_op(make_op(OPC_CURSOR, 16'h0000, 8'd4, 7'h2A));
        send_op(make_op(OPC_CURSOR, 16'h0000, 8'd0, 7'd3));
        send_op(make_op(OPC_CURSOR, 16'h0000, 8'd5, 7'd3));
        send_op(make_op(OPC_CURSOR, 16'h0000, 8'hFF, 7'h7F));
        send_op(make_op(OPC_DATA, 16'h0041, 8'd0, 7'd0));
    endtask

    task automatic test_timing_extremes();
        set_timing(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        send_op(make_op(OPC_INIT, 16'h0000, 8'd0, 7'd0));
        send_op(make_op(OPC_CMD, 16'h0001, 8'd0, 7'd0));
        send_op(make_op(OPC_DATA, 16'h00C5, 8'd0, 7'd0));
        set_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF);
        send_op(make_op(OPC_INIT, 16'h0000, 8'd0, 7'd0));
        send_op(make_op(OPC_CMD, 16'h0001, 8'd0, 7'd0));
        send_op(make_op(OPC_CMD, 16'h0028, 8'd0, 7'd0));
        send_op(make_op(OPC_DATA, 16'h0033, 8'd0, 7'd0));
        send_op(make_op(OPC_CURSOR, 16'h0000, 8'd4, 7'h7F));
    endtask

    task automatic test_random_ops();
        cmd_t        c;
        int unsigned done_ops;
        done_ops = 0;
        while (done_ops < RANDOM_OPS)
        begin
            if (done_ops % 40 == 0)
                set_timing($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
            if (done_ops % 20 == 0)
            begin
                send_gaps   = $urandom_range(0, 3) != 0;
                recv_stalls = $urandom_range(0, 3) != 0;
            end
            c = random_op();
            send_op(c);
            if (!is_dropped(c))
                done_ops++;
        end
    endtask

    task automatic test_tail_back_to_back();
        cmd_t        c;
        int unsigned done_ops;
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        set_timing(POWERUP_RST, SETUP_RST, EN_HIGH_RST, EN_LOW_RST, CLEAR_RST);
        done_ops    = 0;
        while (done_ops < TAIL_OPS)
        begin
            c = random_op();
            send_op(c);
            if (!is_dropped(c))
                done_ops++;
        end
    endtask

    initial
    begin
        int unsigned burst;
        phase_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (recv_stalls && $urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(1, 4);
                phase_stall = 1'b1;
                repeat (burst - 1) @(negedge clk);
            end
            else
                phase_stall = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && phase_valid && !phase_stall)
        begin
            if (expected_phases.size() == 0)
            begin
                err_cnt++;
                $display("%0t unexpected phase beat: actual sel=%b en=%b nib=%h hold=%0d last=%b",
                         $realtime, phase.reg_select, phase.enable, phase.nibble,
                         phase.hold_us, phase.last);
            end
            else
            begin
                want_phase = expected_phases.pop_front();
                phases_seen++;
                if (phase !== want_phase)
                begin
                    err_cnt++;
                    $display("%0t phase mismatch: expected sel=%b en=%b nib=%h hold=%0d last=%b",
                             $realtime, want_phase.reg_select, want_phase.enable,
                             want_phase.nibble, want_phase.hold_us, want_phase.last);
                    $display("%0t                 actual   sel=%b en=%b nib=%h hold=%0d last=%b",
                             $realtime, phase.reg_select, phase.enable, phase.nibble,
                             phase.hold_us, phase.last);
                end
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cmd_valid    = 1'b0;
        cmd          = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        send_gaps    = 1'b1;
        recv_stalls  = 1'b1;
        powerup_wait = POWERUP_RST;
        setup_hold   = SETUP_RST;
        en_high_hold = EN_HIGH_RST;
        en_low_hold  = EN_LOW_RST;
        clear_extra  = CLEAR_RST;
        pin_select   = 1'b0;
        pin_nibble   = 4'h0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_ops();
        test_timing_extremes();
        test_random_ops();
        test_tail_back_to_back();
        wait_idle();

        $display("ran %0d operations (%0d dropped cursor rows) under %0d timing settings",
                 ops_sent, ops_ignored, settings_used + 1);
        $display("checked %0d phase beats, %0d mismatches", phases_seen, err_cnt);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
